// ===== rtl/pal_pkg.sv =====
// Shared types and codes for the positional array list.
`timescale 1ns / 1ps

package pal_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOCATE = 2'd2,
    OP_GET    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_APPLY
  } pal_state_e;

  typedef struct packed {
    kind_e              kind;
    logic [6:0]         position;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] read_value;
    logic [6:0]         found_at;
    logic [6:0]         count;
    logic               is_empty;
    logic               is_full;
  } out_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic        wave;
    logic        scan;
    logic        locate;
    logic        pick;
    logic        shift_up;
    logic        shift_dn;
    logic [31:0] value;
  } cell_ctl_t;

endpackage

// ===== rtl/positional_array_list.sv =====
// Top level of the positional array list: controller and chain of entry cells.
//
//   channel  direction  handshake                 word
//   in       input      in_valid_i / in_ready_o   in_t  (kind, position, value)
//   out      output     out_valid_o / out_ready_i out_t (status, read_value, ...)
//
// After acceptance, each word passes through a load state, then scan states while the
// search wave walks the chain of cells, then an apply state that shifts the chain;
// only then can the next word be accepted.
// The apply cycle waits while the output register still holds an untaken result.
// Reset clears the entry count; entry contents are undefined until written.
`timescale 1ns / 1ps

module positional_array_list import pal_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = ((FW > 7) ? FW : 7) + 1;
  localparam logic [IW-1:0] SCAN_LAST = IW'(CAPACITY - 2);
  localparam logic [FW-1:0] FILL_MAX  = FW'(CAPACITY);

  pal_state_e    state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic [FW-1:0] fill_q, fill_d, fill_new;
  in_t           item_q, item_d;
  out_t          out_q, out_d, res;
  logic          out_valid_q, out_valid_d;
  logic          shift_up, shift_dn;

  logic [CW-1:0] pos_ext, fill_ext, found_ext, count_ext;
  logic          ins_bad, rd_bad, is_full_now, ins_ok, del_ok;
  logic [IW-1:0] tgt;
  cell_ctl_t     ctl;

  logic [31:0]   cell_data [CAPACITY];
  logic          wave_hv   [CAPACITY];
  logic [31:0]   wave_hd   [CAPACITY];
  logic [IW-1:0] wave_hi   [CAPACITY];

  assign pos_ext     = CW'(item_q.position);
  assign fill_ext    = CW'(fill_q);
  assign ins_bad     = (item_q.position == 7'd0) || (pos_ext > fill_ext + CW'(1));
  assign rd_bad      = (item_q.position == 7'd0) || (pos_ext > fill_ext);
  assign is_full_now = (fill_q == FILL_MAX);
  assign tgt         = IW'(pos_ext - CW'(1));
  assign ins_ok      = (item_q.kind == OP_INSERT) && !ins_bad && !is_full_now;
  assign del_ok      = (item_q.kind == OP_DELETE) && !rd_bad;

  always_comb begin
    ctl.wave     = (state_q == ST_LOAD) || (state_q == ST_SCAN);
    ctl.scan     = (state_q == ST_SCAN);
    ctl.locate   = (item_q.kind == OP_LOCATE);
    ctl.pick     = ((item_q.kind == OP_DELETE) || (item_q.kind == OP_GET)) && !rd_bad;
    ctl.shift_up = shift_up;
    ctl.shift_dn = shift_dn;
    ctl.value    = item_q.value;
  end

  // Result of the held word, from the entry count and the wave at cell zero.
  always_comb begin
    res.status     = STAT_OK;
    res.read_value = '0;
    res.found_at   = '0;
    fill_new       = fill_q;
    found_ext      = CW'(wave_hi[0]) + CW'(1);
    unique case (item_q.kind)
      OP_INSERT: begin
        if (ins_bad) begin
          res.status = STAT_BADPOS;
        end else if (is_full_now) begin
          res.status = STAT_FULL;
        end else begin
          fill_new = fill_q + 1'b1;
        end
      end
      OP_DELETE: begin
        if (rd_bad) begin
          res.status = STAT_BADPOS;
        end else begin
          res.read_value = wave_hd[0];
          fill_new       = fill_q - 1'b1;
        end
      end
      OP_LOCATE: begin
        if (wave_hv[0]) begin
          res.found_at = found_ext[6:0];
        end
      end
      OP_GET: begin
        if (rd_bad) begin
          res.status = STAT_BADPOS;
        end else begin
          res.read_value = wave_hd[0];
        end
      end
      default: begin
        res.status = STAT_OK;
      end
    endcase
    count_ext    = CW'(fill_new);
    res.count    = count_ext[6:0];
    res.is_empty = (fill_new == '0);
    res.is_full  = (fill_new == FILL_MAX);
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    item_d      = item_q;
    fill_d      = fill_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    shift_up    = 1'b0;
    shift_dn    = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cnt_d   = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_q == SCAN_LAST) begin
          state_d = ST_APPLY;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_APPLY: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res;
          fill_d      = fill_new;
          shift_up    = ins_ok;
          shift_dn    = del_ok;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0]   left_w, right_w, hd_r_w;
    logic          hv_r_w;
    logic [IW-1:0] hi_r_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
      assign hv_r_w  = 1'b0;
      assign hd_r_w  = '0;
      assign hi_r_w  = '0;
    end else begin : g_inner
      assign right_w = cell_data[i+1];
      assign hv_r_w  = wave_hv[i+1];
      assign hd_r_w  = wave_hd[i+1];
      assign hi_r_w  = wave_hi[i+1];
    end

    pal_cell #(
      .INDEX (i),
      .IW    (IW),
      .FW    (FW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .tgt_i   (tgt),
      .fill_i  (fill_q),
      .left_i  (left_w),
      .right_i (right_w),
      .hv_r_i  (hv_r_w),
      .hd_r_i  (hd_r_w),
      .hi_r_i  (hi_r_w),
      .data_o  (cell_data[i]),
      .hv_o    (wave_hv[i]),
      .hd_o    (wave_hd[i]),
      .hi_o    (wave_hi[i])
    );
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/pal_cell.sv =====
// One list entry with its neighbor shift and its stage of the search wave.
`timescale 1ns / 1ps

module pal_cell import pal_pkg::*; #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IW    = 6,
  parameter int unsigned FW    = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_ctl_t     ctl_i,
  input  logic [IW-1:0] tgt_i,
  input  logic [FW-1:0] fill_i,
  input  logic [31:0]   left_i,
  input  logic [31:0]   right_i,
  input  logic          hv_r_i,
  input  logic [31:0]   hd_r_i,
  input  logic [IW-1:0] hi_r_i,
  output logic [31:0]   data_o,
  output logic          hv_o,
  output logic [31:0]   hd_o,
  output logic [IW-1:0] hi_o
);

  localparam logic [IW-1:0] IDX  = IW'(INDEX);
  localparam logic [FW-1:0] IDXF = FW'(INDEX);

  logic [31:0]   data_q, data_d;
  logic          hv_q, hv_d;
  logic [31:0]   hd_q, hd_d;
  logic [IW-1:0] hi_q, hi_d;
  logic          live;
  logic          hit;

  assign live = (IDXF < fill_i);
  assign hit  = (ctl_i.locate && live && (data_q == ctl_i.value)) ||
                (ctl_i.pick && (IDX == tgt_i));

  always_comb begin
    data_d = data_q;
    if (ctl_i.shift_up) begin
      if (IDX > tgt_i) begin
        data_d = left_i;
      end else if (IDX == tgt_i) begin
        data_d = ctl_i.value;
      end
    end else if (ctl_i.shift_dn) begin
      if (IDX >= tgt_i) begin
        data_d = right_i;
      end
    end
  end

  // The wave moves toward cell zero; a lower hit overrides what comes from above,
  // so cell zero ends up with the first match.
  always_comb begin
    hv_d = hv_q;
    hd_d = hd_q;
    hi_d = hi_q;
    if (ctl_i.wave) begin
      if (ctl_i.scan && !hit) begin
        hv_d = hv_r_i;
        hd_d = hd_r_i;
        hi_d = hi_r_i;
      end else begin
        hv_d = hit;
        hd_d = data_q;
        hi_d = IDX;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    hd_q   <= hd_d;
    hi_q   <= hi_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= 1'b0;
    end else begin
      hv_q <= hv_d;
    end
  end

  assign data_o = data_q;
  assign hv_o   = hv_q;
  assign hd_o   = hd_q;
  assign hi_o   = hi_q;

endmodule
